### src/qwau_pkg.sv
package qwau_pkg;

	// word geometry
	localparam int WORD_WIDTH = 64;
	localparam int HALF_WIDTH = 32;
	localparam int CNT_W      = $clog2(WORD_WIDTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_WIDTH - 1);

	// operation codes
	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_EMUL = 3'd3,
		OP_DIV  = 3'd4
	} op_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic mul_step;
		logic div_step;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] op;
		logic       mplier_zero;
		logic       mcand_top;
		logic       divisor_zero;
	} status_t;

	// sign-extend the low half of a word to a full word
	function automatic logic [WORD_WIDTH-1:0] sext_half(input logic [WORD_WIDTH-1:0] v);
		sext_half = {{(WORD_WIDTH-HALF_WIDTH){v[HALF_WIDTH-1]}}, v[HALF_WIDTH-1:0]};
	endfunction

endpackage

### src/qwau_in_if.sv
interface qwau_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [2:0]                           operation;
	logic [qwau_pkg::WORD_WIDTH-1:0]      operand_a;
	logic [qwau_pkg::WORD_WIDTH-1:0]      operand_b;

	modport source (output valid, output operation, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input operation, input operand_a, input operand_b,
		output ready);
endinterface

### src/qwau_out_if.sv
interface qwau_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [qwau_pkg::WORD_WIDTH-1:0]      result_value;
	logic signed [qwau_pkg::HALF_WIDTH-1:0] remainder_value;
	logic                                 overflow_flag;
	logic                                 divide_by_zero;

	modport source (output valid, output result_value, output remainder_value,
		output overflow_flag, output divide_by_zero, input ready);
	modport sink (input valid, input result_value, input remainder_value,
		input overflow_flag, input divide_by_zero, output ready);
endinterface

### src/quad_word_arith_unit.sv
// 64-bit arithmetic unit: add, subtract, shift-add multiply and divide.
//
// Channels: in_ch takes one item (operation, operand_a, operand_b) when
// valid and ready are both high; out_ch gives one result item per input
// item (result_value, remainder_value, overflow_flag, divide_by_zero).
//
// One item is worked at a time. in_ch.ready is high only while the unit is
// idle. After acceptance the controller works the item in ST_RUN: add,
// subtract and unused codes leave without a step, divide steps once per
// quotient bit (or leaves without a step on a zero divisor), and multiply
// steps once per multiplier bit until the multiplier runs out or a step
// with the top multiplicand bit set raises overflow. ST_FIN then loads the
// output register and raises out_ch.valid. The next item can be accepted in
// the cycle after the load. The shift-add and restoring-divide steps each
// handle one bit per cycle.
//
// The output register parts the two sides: the next item is accepted while
// a result still waits. When the receiver stalls, a finished result holds in
// the controller until the output slot frees. Reset clears the controller
// and the output valid; no result is pending after reset.
module quad_word_arith_unit (
	input  logic       clk,
	input  logic       arst_n,
	qwau_in_if.sink    in_ch,
	qwau_out_if.source out_ch
);

	qwau_pkg::cmd_t    cmd;
	qwau_pkg::status_t status;

	qwau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	qwau_dpath u_dpath (
		.clk             (clk),
		.cmd             (cmd),
		.operation       (in_ch.operation),
		.operand_a       (in_ch.operand_a),
		.operand_b       (in_ch.operand_b),
		.status          (status),
		.result_value    (out_ch.result_value),
		.remainder_value (out_ch.remainder_value),
		.overflow_flag   (out_ch.overflow_flag),
		.divide_by_zero  (out_ch.divide_by_zero)
	);

	// a load of the output register always presents a result next cycle
	a_out_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_ch.valid)
		else $error("result loaded but not presented");

	// never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_ch.valid || out_ch.ready))
		else $error("output register overwritten while stalled");

	// one item in flight: acceptance closes the input until the work ends
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("second item accepted while busy");

	// overflow and divide-by-zero come from different operations
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !(out_ch.overflow_flag && out_ch.divide_by_zero))
		else $error("both flags raised on one result");

endmodule

### src/qwau_ctrl.sv
module qwau_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  qwau_pkg::status_t   status,
	output qwau_pkg::cmd_t      cmd
);

	qwau_pkg::state_t state_q, state_n;
	logic [qwau_pkg::CNT_W-1:0] cnt_q, cnt_n;
	logic out_valid_q, out_valid_n;

	// state, step count and output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= qwau_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			cnt_q       <= cnt_n;
			out_valid_q <= out_valid_n;
		end
	end

	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_n  = state_q;
		cnt_n    = cnt_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			qwau_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_n    = '0;
					state_n  = qwau_pkg::ST_RUN;
				end
			end
			qwau_pkg::ST_RUN: begin
				case (status.op)
					qwau_pkg::OP_MUL, qwau_pkg::OP_EMUL: begin
						if (status.mplier_zero) begin
							state_n = qwau_pkg::ST_FIN;
						end else begin
							cmd.mul_step = 1'b1;
							// top bit set: this step raises overflow and ends
							if (status.mcand_top) begin
								state_n = qwau_pkg::ST_FIN;
							end
						end
					end
					qwau_pkg::OP_DIV: begin
						if (status.divisor_zero) begin
							state_n = qwau_pkg::ST_FIN;
						end else begin
							cmd.div_step = 1'b1;
							cnt_n        = cnt_q + 1'b1;
							if (cnt_q == qwau_pkg::CNT_LAST) begin
								state_n = qwau_pkg::ST_FIN;
							end
						end
					end
					default: begin
						state_n = qwau_pkg::ST_FIN;
					end
				endcase
			end
			qwau_pkg::ST_FIN: begin
				// hold until the output slot is free or being emptied
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_n      = qwau_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = qwau_pkg::ST_IDLE;
			end
		endcase

		out_valid_n = out_valid_q;
		if (cmd.out_load) begin
			out_valid_n = 1'b1;
		end else if (out_ready) begin
			out_valid_n = 1'b0;
		end
	end

endmodule

### src/qwau_dpath.sv
module qwau_dpath (
	input  logic                                  clk,
	input  qwau_pkg::cmd_t                        cmd,
	input  logic [2:0]                            operation,
	input  logic [qwau_pkg::WORD_WIDTH-1:0]       operand_a,
	input  logic [qwau_pkg::WORD_WIDTH-1:0]       operand_b,
	output qwau_pkg::status_t                     status,
	output logic [qwau_pkg::WORD_WIDTH-1:0]       result_value,
	output logic signed [qwau_pkg::HALF_WIDTH-1:0] remainder_value,
	output logic                                  overflow_flag,
	output logic                                  divide_by_zero
);

	localparam int W = qwau_pkg::WORD_WIDTH;
	localparam int H = qwau_pkg::HALF_WIDTH;

	// x: multiplicand, or dividend shifting into quotient
	// y: multiplier, or divisor
	logic [2:0]   op_q;
	logic [W-1:0] x_q, y_q, acc_q, rem_q;
	logic         ovf_q;
	logic [W-1:0] res_q;
	logic [H-1:0] rem_out_q;
	logic         ovf_out_q, dz_out_q;

	logic [W-1:0] acc_add;
	logic [W:0]   partial, trial;
	logic         is_div, dz;
	logic [W-1:0] x_load, y_load, acc_load;

	assign acc_add = y_q[0] ? acc_q + x_q : acc_q;
	assign partial = {rem_q, x_q[W-1]};
	assign trial   = partial - {1'b0, y_q};
	assign is_div  = (op_q == qwau_pkg::OP_DIV);
	assign dz      = (y_q == '0);

	assign status.op           = op_q;
	assign status.mplier_zero  = (y_q == '0);
	assign status.mcand_top    = x_q[W-1];
	assign status.divisor_zero = dz;

	// operand values taken at load
	always_comb begin
		x_load   = operand_a;
		y_load   = operand_b;
		acc_load = '0;
		case (operation)
			qwau_pkg::OP_ADD:  acc_load = operand_a + operand_b;
			qwau_pkg::OP_SUB:  acc_load = operand_a - operand_b;
			qwau_pkg::OP_EMUL: begin
				x_load = qwau_pkg::sext_half(operand_a);
				y_load = qwau_pkg::sext_half(operand_b);
			end
			qwau_pkg::OP_DIV:  y_load = qwau_pkg::sext_half(operand_b);
			default: ;
		endcase
	end

	// operand load and iteration
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			ovf_q <= 1'b0;
			rem_q <= '0;
			x_q   <= x_load;
			y_q   <= y_load;
			acc_q <= acc_load;
		end else if (cmd.mul_step) begin
			acc_q <= acc_add;
			if (x_q[W-1]) begin
				ovf_q <= 1'b1;
			end else begin
				x_q <= {x_q[W-2:0], 1'b0};
				y_q <= {1'b0, y_q[W-1:1]};
			end
		end else if (cmd.div_step) begin
			// restoring step: keep the difference when it does not go negative
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				x_q   <= {x_q[W-2:0], 1'b1};
			end else begin
				rem_q <= partial[W-1:0];
				x_q   <= {x_q[W-2:0], 1'b0};
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (is_div) begin
				res_q     <= dz ? '0 : {{(W-H){1'b0}}, x_q[H-1:0]};
				rem_out_q <= dz ? '0 : rem_q[H-1:0];
			end else begin
				res_q     <= acc_q;
				rem_out_q <= '0;
			end
			ovf_out_q <= ovf_q;
			dz_out_q  <= is_div && dz;
		end
	end

	assign result_value    = res_q;
	assign remainder_value = rem_out_q;
	assign overflow_flag   = ovf_out_q;
	assign divide_by_zero  = dz_out_q;

endmodule

### tb/quad_word_arith_unit_tb.sv
`timescale 1ns / 1ps

module quad_word_arith_unit_tb;

	localparam int WORD_WIDTH = qwau_pkg::WORD_WIDTH;
	localparam int HALF_WIDTH = qwau_pkg::HALF_WIDTH;

	typedef logic [WORD_WIDTH-1:0] word_t;

	typedef struct packed {
		word_t                 result_value;
		logic [HALF_WIDTH-1:0] remainder_value;
		logic                  overflow_flag;
		logic                  divide_by_zero;
	} arith_outcome_t;

	// codes past the last defined operation
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

	localparam int RANDOM_ITEMS     = 1225;
	localparam int LONG_HOLD_AT     = 400;
	localparam int LONG_HOLD_CYCLES = 600;
	localparam int TAIL_CYCLES      = 150;
	localparam int WATCHDOG_LIMIT   = 5000;

	// expected arithmetic outcomes, oldest first
	class arith_expectations;
		arith_outcome_t pending[$];
		int errors = 0;
		int overflows = 0;
		int zero_divides = 0;

		function word_t widen_half(word_t v);
			return {{(WORD_WIDTH-HALF_WIDTH){v[HALF_WIDTH-1]}}, v[HALF_WIDTH-1:0]};
		endfunction

		// shift-add loop that stops as soon as the multiplicand reaches the top bit
		function void shift_add_product(input word_t mcand, input word_t mplier,
				output word_t acc, output logic ovf);
			acc = '0;
			ovf = 1'b0;
			while (mplier != '0 && !ovf) begin
				if (mplier[0])
					acc = acc + mcand;
				if (mcand[WORD_WIDTH-1]) begin
					ovf = 1'b1;
				end else begin
					mcand = mcand << 1;
					mplier = mplier >> 1;
				end
			end
		endfunction

		function arith_outcome_t compute_outcome(logic [2:0] op, word_t a, word_t b);
			arith_outcome_t o;
			word_t divisor;
			word_t quo;
			word_t rem;
			o = '0;
			case (op)
				qwau_pkg::OP_ADD: o.result_value = a + b;
				qwau_pkg::OP_SUB: o.result_value = a - b;
				qwau_pkg::OP_MUL: shift_add_product(a, b, o.result_value, o.overflow_flag);
				qwau_pkg::OP_EMUL: shift_add_product(widen_half(a), widen_half(b),
					o.result_value, o.overflow_flag);
				qwau_pkg::OP_DIV: begin
					divisor = widen_half(b);
					if (divisor == '0) begin
						o.divide_by_zero = 1'b1;
					end else begin
						quo = a / divisor;
						rem = a % divisor;
						o.result_value = word_t'(quo[HALF_WIDTH-1:0]);
						o.remainder_value = rem[HALF_WIDTH-1:0];
					end
				end
				default: ;
			endcase
			return o;
		endfunction

		function void log_operands(logic [2:0] op, word_t a, word_t b);
			arith_outcome_t o;
			o = compute_outcome(op, a, b);
			if (o.overflow_flag)
				overflows++;
			if (o.divide_by_zero)
				zero_divides++;
			pending.push_back(o);
		endfunction

		function void check_outcome(arith_outcome_t got);
			arith_outcome_t want;
			if (pending.size() == 0) begin
				$error("unexpected result item: result_value %h", got.result_value);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.result_value !== want.result_value) begin
				$error("result_value expected %h actual %h",
					want.result_value, got.result_value);
				errors++;
			end
			if (got.remainder_value !== want.remainder_value) begin
				$error("remainder_value expected %0d actual %0d",
					$signed(want.remainder_value), $signed(got.remainder_value));
				errors++;
			end
			if (got.overflow_flag !== want.overflow_flag) begin
				$error("overflow_flag expected %b actual %b",
					want.overflow_flag, got.overflow_flag);
				errors++;
			end
			if (got.divide_by_zero !== want.divide_by_zero) begin
				$error("divide_by_zero expected %b actual %b",
					want.divide_by_zero, got.divide_by_zero);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	qwau_in_if  in_ch();
	qwau_out_if out_ch();

	quad_word_arith_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	arith_expectations expected_arith = new();

	int ops_taken[8];
	int items_taken = 0;
	int results_taken = 0;
	int quiet_cycles = 0;
	bit sender_burst = 1'b0;
	bit receiver_burst = 1'b0;

	always #10 clk = ~clk;

	// end the run if nothing moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// offer one item after a random gap and hold it until accepted
	task automatic send_item(input logic [2:0] op, input word_t a, input word_t b);
		int gap;
		gap = sender_burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.operation <= op;
		in_ch.operand_a <= a;
		in_ch.operand_b <= b;
		do @(posedge clk); while (!in_ch.ready);
		expected_arith.log_operands(op, a, b);
		ops_taken[op]++;
		items_taken++;
	endtask

	// stop offering until every pending result has come back
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_arith.pending.size() != 0);
	endtask

	function automatic word_t pick_word();
		word_t w;
		case ($urandom_range(0, 6))
			0, 1: w = {$urandom, $urandom};
			2: w = word_t'($urandom_range(0, 255));
			3: w = word_t'($urandom);
			4: w = word_t'(1) << $urandom_range(0, WORD_WIDTH - 1);
			5: w = {$urandom, 1'b1, 31'($urandom)};
			default: begin
				case ($urandom_range(0, 5))
					0: w = '0;
					1: w = '1;
					2: w = 64'h8000_0000_0000_0000;
					3: w = 64'h7FFF_FFFF_FFFF_FFFF;
					4: w = 64'h0000_0000_8000_0000;
					default: w = 64'h0000_0000_FFFF_FFFF;
				endcase
			end
		endcase
		return w;
	endfunction

	task automatic run_directed();
		// wrap on add and subtract
		send_item(qwau_pkg::OP_ADD, '1, 64'h1);
		send_item(qwau_pkg::OP_ADD, '1, '1);
		send_item(qwau_pkg::OP_SUB, '0, 64'h1);
		send_item(qwau_pkg::OP_SUB, 64'h1234_5678_9ABC_DEF0, 64'h1234_5678_9ABC_DEF0);
		// multiply: empty multiplier, plain product, early stop at the first, second and last step
		send_item(qwau_pkg::OP_MUL, 64'h8000_0000_0000_0000, '0);
		send_item(qwau_pkg::OP_MUL, '0, '1);
		send_item(qwau_pkg::OP_MUL, 64'd3, 64'd5);
		send_item(qwau_pkg::OP_MUL, 64'h8000_0000_0000_0000, 64'h1);
		send_item(qwau_pkg::OP_MUL, 64'h8000_0000_0000_0000, 64'h2);
		send_item(qwau_pkg::OP_MUL, 64'h4000_0000_0000_0000, 64'h2);
		send_item(qwau_pkg::OP_MUL, 64'h1, '1);
		send_item(qwau_pkg::OP_MUL, '1, '1);
		// extended multiply ignores the upper halves
		send_item(qwau_pkg::OP_EMUL, 64'hDEAD_BEEF_0000_0003, 64'hFFFF_FFFF_0000_0005);
		send_item(qwau_pkg::OP_EMUL, 64'h0000_0000_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF);
		send_item(qwau_pkg::OP_EMUL, 64'h0000_0000_7FFF_FFFF, 64'h2);
		send_item(qwau_pkg::OP_EMUL, 64'h0000_0000_8000_0000, 64'h1);
		// divide: plain, negative divisors, small dividend, zero divisor
		send_item(qwau_pkg::OP_DIV, 64'd100, 64'd7);
		send_item(qwau_pkg::OP_DIV, '1, 64'h1);
		send_item(qwau_pkg::OP_DIV, '1, 64'h0000_0000_FFFF_FFFF);
		send_item(qwau_pkg::OP_DIV, '1, 64'h0000_0000_8000_0000);
		send_item(qwau_pkg::OP_DIV, 64'd5, 64'd9);
		send_item(qwau_pkg::OP_DIV, '1, 64'h7FFF_FFFF);
		send_item(qwau_pkg::OP_DIV, '1, 64'hFFFF_FFFF_0000_0000);
		// unused codes give all zeros
		send_item(OP_SPARE_FIRST, '1, '1);
		send_item(3'(OP_SPARE_FIRST + 3'd1), '1, 64'h1);
		send_item(OP_SPARE_LAST, 64'h8000_0000_0000_0000, '1);
	endtask

	task automatic run_random();
		logic [2:0] op;
		word_t a;
		word_t b;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0)
				sender_burst = ($urandom_range(0, 3) == 0);
			if (n == RANDOM_ITEMS / 2)
				drain_results();
			case ($urandom_range(0, 9))
				0: op = qwau_pkg::OP_ADD;
				1: op = qwau_pkg::OP_SUB;
				2, 3: op = qwau_pkg::OP_MUL;
				4, 5: op = qwau_pkg::OP_EMUL;
				6, 7: op = qwau_pkg::OP_DIV;
				8: op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
				default: op = 3'($urandom);
			endcase
			a = pick_word();
			b = pick_word();
			if (op == qwau_pkg::OP_DIV && $urandom_range(0, 7) == 0)
				b[HALF_WIDTH-1:0] = '0;
			send_item(op, a, b);
		end
	endtask

	// take results, stalling at random and once for a long stretch
	initial begin
		int stall;
		arith_outcome_t got;
		out_ch.ready <= 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (results_taken % 40 == 0)
				receiver_burst = ($urandom_range(0, 3) == 0);
			if (results_taken == LONG_HOLD_AT)
				stall = LONG_HOLD_CYCLES;
			else
				stall = receiver_burst ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			got.result_value = out_ch.result_value;
			got.remainder_value = out_ch.remainder_value;
			got.overflow_flag = out_ch.overflow_flag;
			got.divide_by_zero = out_ch.divide_by_zero;
			expected_arith.check_outcome(got);
			results_taken++;
		end
	end

	initial begin
		in_ch.valid <= 1'b0;
		in_ch.operation <= qwau_pkg::OP_ADD;
		in_ch.operand_a <= '0;
		in_ch.operand_b <= '0;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		drain_results();
		run_random();
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d items: add %0d, sub %0d, mul %0d, ext mul %0d, div %0d, spare codes %0d",
			items_taken, ops_taken[qwau_pkg::OP_ADD], ops_taken[qwau_pkg::OP_SUB],
			ops_taken[qwau_pkg::OP_MUL], ops_taken[qwau_pkg::OP_EMUL],
			ops_taken[qwau_pkg::OP_DIV],
			ops_taken[OP_SPARE_FIRST] + ops_taken[3'(OP_SPARE_FIRST + 3'd1)]
				+ ops_taken[OP_SPARE_LAST]);
		$display("%0d results checked, %0d multiply early stops, %0d zero divisors",
			results_taken, expected_arith.overflows, expected_arith.zero_divides);
		if (expected_arith.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
